// ----- hdl/bce_pkg.sv -----
// Shared item types and constants of the Bezier curve evaluator.
`timescale 1ns / 1ps
package bce_pkg;

	localparam int unsigned T_ONE = 65536;
	localparam int unsigned T_FRAC = 16;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_EVAL = 1'b1
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [5:0]         piece;
		logic [3:0]         index;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic               last_point;
		logic [16:0]        t_param;
	} cmd_item_t;

	typedef struct packed {
		logic signed [31:0] qx;
		logic signed [31:0] qy;
		logic signed [31:0] qz;
		logic [6:0]         piece_total;
	} res_item_t;

endpackage

// ----- hdl/bce_stream_if.sv -----
// Valid/ready stream channel carrying one item type.
`timescale 1ns / 1ps
interface bce_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/bce_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/bezier_curve_evaluator.sv -----
// Top level: piecewise Bezier curve store and de Casteljau evaluator.
`timescale 1ns / 1ps
// Usage
//   cmd : input items. func=load writes one control point (px,py,pz) at
//         (piece,index); last_point also sets the piece's point count to
//         index+1 and raises piece_total. func=eval evaluates the piece at
//         t_param (Q1.16, clamped to 1.0) and gives one res item.
//   res : result items (qx,qy,qz saturated Q16.16, piece_total).
// Operation
//   A load is written as it is accepted; cmd stays ready. An eval of n points
//   reads the count, copies the points into scratch, per level k = n-1..1
//   runs setup (S_LEV, S_LA) and k lerps, then finishes (S_FIN, S_OUT); an empty
//   piece gives zeros. The one scratch read port paces one lerp (all axes) at a time.
// Reset
//   After arst_n is released the point count RAM is cleared, one piece per
//   cycle, for all MAX_PIECES pieces; cmd.ready stays low meanwhile.
// Stalls
//   The result sits in an output register; cmd is taken again while it
//   waits. A finished eval holds until the register is free.
module bezier_curve_evaluator #(
	parameter int MAX_POINTS = 16,
	parameter int MAX_PIECES = 64,
	parameter int COORD_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	bce_stream_if.sink        cmd,
	bce_stream_if.source      res
);
	import bce_pkg::*;

	localparam int CW  = COORD_BITS;
	localparam int PW  = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
	localparam int XW  = $clog2(MAX_POINTS);
	localparam int CNW = $clog2(MAX_POINTS + 1);
	localparam int PAW = (MAX_PIECES * MAX_POINTS > 1) ? $clog2(MAX_PIECES * MAX_POINTS) : 1;
	localparam int PRW = CW + 18;
	localparam logic signed [63:0] CMAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
	localparam logic signed [63:0] CMIN = -CMAX - 64'sd1;
	localparam logic signed [63:0] OMAX = 64'sd2147483647;
	localparam logic signed [63:0] OMIN = -64'sd2147483648;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CNT, S_COPY, S_LEV, S_LA, S_MUL, S_WR, S_FIN, S_OUT
	} state_t;

	function automatic logic signed [CW-1:0] sat_in(input logic signed [31:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		if (w > CMAX) w = CMAX;
		if (w < CMIN) w = CMIN;
		return CW'(w);
	endfunction

	function automatic logic signed [31:0] sat_out(input logic signed [CW-1:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		if (w > OMAX) w = OMAX;
		if (w < OMIN) w = OMIN;
		return 32'(w);
	endfunction

	state_t state_q;
	logic [PW-1:0]  clr_q;
	logic [PAW-1:0] base_q;
	logic           pok_q;
	logic [16:0]    t_q;
	logic [CNW-1:0] n_q;
	logic [CNW-1:0] cp_q;
	logic [XW-1:0]  k_q;
	logic [XW-1:0]  i_q;
	logic [6:0]     total_q;
	logic signed [CW-1:0]  a_q [3];
	logic signed [CW-1:0]  b_q [3];
	logic signed [PRW-1:0] prod_q [3];
	logic signed [31:0]    res_q [3];

	// count RAM
	logic           cnt_we;
	logic [PW-1:0]  cnt_waddr;
	logic [CNW-1:0] cnt_wdata;
	logic [CNW-1:0] cnt_rdata;
	// point RAM, {z,y,x}
	logic             pt_we;
	logic [PAW-1:0]   pt_waddr;
	logic [3*CW-1:0]  pt_wdata;
	logic [PAW-1:0]   pt_raddr;
	logic [3*CW-1:0]  pt_rdata;
	// scratch RAM, {z,y,x}
	logic             scr_we;
	logic [XW-1:0]    scr_waddr;
	logic [3*CW-1:0]  scr_wdata;
	logic [XW-1:0]    scr_raddr;
	logic [3*CW-1:0]  scr_rdata;

	logic            accept;
	logic            piece_ok;
	logic            index_ok;
	logic [PAW-1:0]  cmd_base;
	logic signed [CW-1:0]  rd_ax [3];
	logic signed [CW-1:0]  new_ax [3];
	logic signed [CW:0]    diff [3];

	assign accept   = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign piece_ok = (int'(cmd.data.piece) < MAX_PIECES);
	assign index_ok = (int'(cmd.data.index) < MAX_POINTS);
	assign cmd_base = PAW'(cmd.data.piece) * PAW'(MAX_POINTS);

	always_comb begin
		for (int ax = 0; ax < 3; ax++) begin
			rd_ax[ax]  = scr_rdata[ax*CW +: CW];
			diff[ax]   = {rd_ax[ax][CW-1], rd_ax[ax]} - {a_q[ax][CW-1], a_q[ax]};
			new_ax[ax] = a_q[ax] + CW'(prod_q[ax] >>> T_FRAC);
		end
	end

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = PW'(cmd.data.piece);
		cnt_wdata = CNW'(cmd.data.index) + CNW'(1);
		pt_we     = accept && cmd.data.func == FUNC_LOAD && piece_ok && index_ok;
		pt_waddr  = cmd_base + PAW'(cmd.data.index);
		pt_wdata  = {sat_in(cmd.data.pz), sat_in(cmd.data.py), sat_in(cmd.data.px)};
		pt_raddr  = base_q + PAW'(cp_q);
		scr_we    = 1'b0;
		scr_waddr = i_q;
		scr_wdata = {new_ax[2], new_ax[1], new_ax[0]};
		scr_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
				cnt_wdata = '0;
			end
			S_IDLE: begin
				cnt_we = pt_we && cmd.data.last_point;
			end
			S_COPY: begin
				scr_we    = (cp_q != '0);
				scr_waddr = XW'(cp_q - CNW'(1));
				scr_wdata = pt_rdata;
			end
			S_LA:  scr_raddr = XW'(1);
			S_WR: begin
				scr_we    = 1'b1;
				scr_raddr = i_q + XW'(2);
			end
			default: scr_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			total_q   <= '0;
			res.valid <= 1'b0;
		end else begin
			// S_OUT owns res.valid while it hands over a new item
			if (res.valid && res.ready && state_q != S_OUT) begin
				res.valid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + PW'(1);
					if (clr_q == PW'(MAX_PIECES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (cmd.data.func == FUNC_LOAD) begin
							if (pt_we && cmd.data.last_point &&
							    total_q < {1'b0, cmd.data.piece} + 7'd1) begin
								total_q <= {1'b0, cmd.data.piece} + 7'd1;
							end
						end else begin
							pok_q   <= piece_ok;
							base_q  <= cmd_base;
							t_q     <= (cmd.data.t_param > 17'(T_ONE)) ? 17'(T_ONE)
							                                           : cmd.data.t_param;
							state_q <= S_CNT;
						end
					end
				end
				S_CNT: begin
					n_q  <= cnt_rdata;
					cp_q <= '0;
					if (!pok_q || cnt_rdata == '0) begin
						for (int ax = 0; ax < 3; ax++) res_q[ax] <= '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_COPY;
					end
				end
				S_COPY: begin
					cp_q <= cp_q + CNW'(1);
					if (cp_q == n_q) begin
						k_q     <= XW'(n_q - CNW'(1));
						state_q <= S_LEV;
					end
				end
				S_LEV: begin
					state_q <= (k_q == '0) ? S_FIN : S_LA;
				end
				S_LA: begin
					for (int ax = 0; ax < 3; ax++) a_q[ax] <= rd_ax[ax];
					i_q     <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					for (int ax = 0; ax < 3; ax++) begin
						prod_q[ax] <= PRW'(diff[ax]) * PRW'($signed({1'b0, t_q}));
						b_q[ax]    <= rd_ax[ax];
					end
					state_q <= S_WR;
				end
				S_WR: begin
					for (int ax = 0; ax < 3; ax++) a_q[ax] <= b_q[ax];
					if ({1'b0, i_q} + (XW+1)'(1) == {1'b0, k_q}) begin
						k_q     <= k_q - XW'(1);
						state_q <= S_LEV;
					end else begin
						i_q     <= i_q + XW'(1);
						state_q <= S_MUL;
					end
				end
				S_FIN: begin
					for (int ax = 0; ax < 3; ax++) res_q[ax] <= sat_out(rd_ax[ax]);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!res.valid || res.ready) begin
						res.valid            <= 1'b1;
						res.data.qx          <= res_q[0];
						res.data.qy          <= res_q[1];
						res.data.qz          <= res_q[2];
						res.data.piece_total <= total_q;
						state_q              <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	bce_ram #(.WIDTH(CNW), .DEPTH(MAX_PIECES)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (PW'(cmd.data.piece)),
		.rdata (cnt_rdata)
	);

	bce_ram #(.WIDTH(3 * CW), .DEPTH(MAX_PIECES * MAX_POINTS)) u_pt_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	bce_ram #(.WIDTH(3 * CW), .DEPTH(MAX_POINTS)) u_scr_ram (
		.clk   (clk),
		.we    (scr_we),
		.waddr (scr_waddr),
		.wdata (scr_wdata),
		.raddr (scr_raddr),
		.rdata (scr_rdata)
	);
endmodule
